// ===== rtl/qvr_pkg.sv =====
// Shared types, widths and register codes for the quaternion vector rotator.
`timescale 1ns / 1ps
`default_nettype none
package qvr_pkg;

  localparam int QW     = 16;  // quaternion component width, Q2.14
  localparam int VW     = 32;  // vector component width, Q16.16
  localparam int MW     = 34;  // rotation matrix entry width, Q.28
  localparam int QRW    = 42;  // rounded dot product before clipping

  typedef logic signed [QW-1:0]  quat_t;
  typedef logic signed [VW-1:0]  vcomp_t;
  typedef logic signed [MW-1:0]  ment_t;
  typedef logic signed [QRW-1:0] qres_t;

  typedef ment_t  [2:0] mrow_t;
  typedef mrow_t  [2:0] mat_t;
  typedef vcomp_t [2:0] vec_t;

  // Load enables, one per pipeline stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } pipe_en_t;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_QUAT_X = 2'd0;
  localparam logic [1:0] REG_QUAT_Y = 2'd1;
  localparam logic [1:0] REG_QUAT_Z = 2'd2;
  localparam logic [1:0] REG_QUAT_W = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/qvr_matrix.sv =====
// Two pipeline stages that turn the quaternion into its rotation matrix.
`timescale 1ns / 1ps
`default_nettype none
module qvr_matrix (
  input  wire               clk,
  input  qvr_pkg::pipe_en_t en,
  input  qvr_pkg::quat_t    qx,
  input  qvr_pkg::quat_t    qy,
  input  qvr_pkg::quat_t    qz,
  input  qvr_pkg::quat_t    qw,
  output qvr_pkg::mat_t     mat
);
  import qvr_pkg::*;

  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [31:0] ww_nxt, xx_nxt, yy_nxt, zz_nxt, xy_nxt, xz_nxt, yz_nxt;
  logic signed [31:0] wx_nxt, wy_nxt, wz_nxt;
  ment_t ww_e, xx_e, yy_e, zz_e, xy_e, xz_e, yz_e, wx_e, wy_e, wz_e;
  mat_t  mat_r, mat_nxt;

  // First stage: the ten distinct component products.
  always_comb begin
    ww_nxt = qw * qw;
    xx_nxt = qx * qx;
    yy_nxt = qy * qy;
    zz_nxt = qz * qz;
    xy_nxt = qx * qy;
    xz_nxt = qx * qz;
    yz_nxt = qy * qz;
    wx_nxt = qw * qx;
    wy_nxt = qw * qy;
    wz_nxt = qw * qz;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ww_r <= ww_nxt;
      xx_r <= xx_nxt;
      yy_r <= yy_nxt;
      zz_r <= zz_nxt;
      xy_r <= xy_nxt;
      xz_r <= xz_nxt;
      yz_r <= yz_nxt;
      wx_r <= wx_nxt;
      wy_r <= wy_nxt;
      wz_r <= wz_nxt;
    end
  end

  // Second stage: matrix entries, each scaled by the squared norm.
  always_comb begin
    ww_e = MW'(ww_r);
    xx_e = MW'(xx_r);
    yy_e = MW'(yy_r);
    zz_e = MW'(zz_r);
    xy_e = MW'(xy_r);
    xz_e = MW'(xz_r);
    yz_e = MW'(yz_r);
    wx_e = MW'(wx_r);
    wy_e = MW'(wy_r);
    wz_e = MW'(wz_r);
    mat_nxt[0][0] = ww_e + xx_e - yy_e - zz_e;
    mat_nxt[0][1] = (xy_e - wz_e) <<< 1;
    mat_nxt[0][2] = (xz_e + wy_e) <<< 1;
    mat_nxt[1][0] = (xy_e + wz_e) <<< 1;
    mat_nxt[1][1] = ww_e - xx_e + yy_e - zz_e;
    mat_nxt[1][2] = (yz_e - wx_e) <<< 1;
    mat_nxt[2][0] = (xz_e - wy_e) <<< 1;
    mat_nxt[2][1] = (yz_e + wx_e) <<< 1;
    mat_nxt[2][2] = ww_e - xx_e - yy_e + zz_e;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      mat_r <= mat_nxt;
    end
  end

  assign mat = mat_r;

endmodule
`default_nettype wire

// ===== rtl/qvr_dot.sv =====
// Three pipeline stages forming one rounded row of the matrix-vector product.
`timescale 1ns / 1ps
`default_nettype none
module qvr_dot (
  input  wire               clk,
  input  qvr_pkg::pipe_en_t en,
  input  qvr_pkg::mrow_t    row,
  input  qvr_pkg::vec_t     vec,
  output qvr_pkg::qres_t    res
);
  import qvr_pkg::*;

  localparam logic signed [69:0] ROUND_HALF = 70'sd134217728;

  logic signed [50:0] plo_r   [3];
  logic signed [50:0] plo_nxt [3];
  logic signed [49:0] phi_r   [3];
  logic signed [49:0] phi_nxt [3];
  logic signed [52:0] slo_r, slo_nxt;
  logic signed [51:0] shi_r, shi_nxt;
  logic signed [69:0] sum_full;
  qres_t              res_r, res_nxt;
  logic signed [16:0] lo_part [3];
  logic signed [15:0] hi_part [3];

  // Each vector component is cut into a signed high half and an unsigned
  // low half so that no multiplier is wider than 34 by 17 bits.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo_part[j] = $signed({1'b0, vec[j][15:0]});
      hi_part[j] = $signed(vec[j][31:16]);
      plo_nxt[j] = $signed(row[j]) * lo_part[j];
      phi_nxt[j] = $signed(row[j]) * hi_part[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int j = 0; j < 3; j++) begin
        plo_r[j] <= plo_nxt[j];
        phi_r[j] <= phi_nxt[j];
      end
    end
  end

  always_comb begin
    slo_nxt = 53'(plo_r[0]) + 53'(plo_r[1]) + 53'(plo_r[2]);
    shi_nxt = 52'(phi_r[0]) + 52'(phi_r[1]) + 52'(phi_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      slo_r <= slo_nxt;
      shi_r <= shi_nxt;
    end
  end

  // Rejoin the halves, add one half LSB and take the floor of the Q.44 sum.
  always_comb begin
    sum_full = (70'(shi_r) <<< 16) + 70'(slo_r) + ROUND_HALF;
    res_nxt  = sum_full[69:28];
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== rtl/quaternion_vector_rotator.sv =====
// Top level of the quaternion vector rotator: registers, pipeline control, clipping.
`timescale 1ns / 1ps
`default_nettype none
// Rotates each input vector by the quaternion in the four configuration
// registers and returns the vector part of q*v*conj(q), scaled by |q|^2
// since q is not normalised. One vector is accepted per cycle while
// in_tready is high. Two stages build the rotation matrix, three form
// and round the dot products, and the last clips to 32 bits and holds
// the result until it is taken. The quaternion is sampled together
// with each vector on acceptance. A stall on the output fills pipeline
// bubbles first and then holds in_tready low.
module quaternion_vector_rotator (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: vec_x [31:0], vec_y [63:32], vec_z [95:64]
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [95:0] in_tdata,
  // out_tdata: rot_x [31:0], rot_y [63:32], rot_z [95:64]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [95:0] out_tdata,
  // out_tuser: saturated [0]
  output logic [0:0]  out_tuser,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import qvr_pkg::*;

  localparam qres_t CLIP_MAX = 42'sd2147483647;
  localparam qres_t CLIP_MIN = -42'sd2147483648;

  quat_t     qx_r, qy_r, qz_r, qw_r;
  logic      cfg_wr;
  logic [1:0] cfg_idx;

  logic [6:1] vld_r, vld_nxt;
  logic [6:1] stage_rdy;
  pipe_en_t   en;

  vec_t  vec1_r, vec2_r;
  mat_t  mat;
  qres_t res [3];

  logic [95:0] odata_r, odata_nxt;
  logic        osat_r, osat_nxt;
  logic [2:0]  clip;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
      qw_r <= 16'sd16384;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_QUAT_X: qx_r <= cfg_pwdata[15:0];
        REG_QUAT_Y: qy_r <= cfg_pwdata[15:0];
        REG_QUAT_Z: qz_r <= cfg_pwdata[15:0];
        REG_QUAT_W: qw_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_QUAT_X: cfg_prdata = {16'd0, qx_r};
      REG_QUAT_Y: cfg_prdata = {16'd0, qy_r};
      REG_QUAT_Z: cfg_prdata = {16'd0, qz_r};
      REG_QUAT_W: cfg_prdata = {16'd0, qw_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    stage_rdy[6] = !vld_r[6] || out_tready;
    for (int k = 5; k >= 1; k--) begin
      stage_rdy[k] = !vld_r[k] || stage_rdy[k+1];
    end
    en.s1 = stage_rdy[1];
    en.s2 = stage_rdy[2];
    en.s3 = stage_rdy[3];
    en.s4 = stage_rdy[4];
    en.s5 = stage_rdy[5];
    en.s6 = stage_rdy[6];
    vld_nxt[1] = stage_rdy[1] ? in_tvalid : vld_r[1];
    for (int k = 2; k <= 6; k++) begin
      vld_nxt[k] = stage_rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = stage_rdy[1];

  // The vector travels alongside the matrix build.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      vec1_r[0] <= in_tdata[31:0];
      vec1_r[1] <= in_tdata[63:32];
      vec1_r[2] <= in_tdata[95:64];
    end
    if (en.s2) begin
      vec2_r <= vec1_r;
    end
  end

  qvr_matrix u_matrix (
    .clk (clk),
    .en  (en),
    .qx  (qx_r),
    .qy  (qy_r),
    .qz  (qz_r),
    .qw  (qw_r),
    .mat (mat)
  );

  for (genvar i = 0; i < 3; i++) begin : g_row
    qvr_dot u_dot (
      .clk (clk),
      .en  (en),
      .row (mat[i]),
      .vec (vec2_r),
      .res (res[i])
    );
  end

  // Output stage: clip each component to 32 bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (res[i] > CLIP_MAX) begin
        clip[i] = 1'b1;
        odata_nxt[32*i +: 32] = CLIP_MAX[31:0];
      end else if (res[i] < CLIP_MIN) begin
        clip[i] = 1'b1;
        odata_nxt[32*i +: 32] = CLIP_MIN[31:0];
      end else begin
        clip[i] = 1'b0;
        odata_nxt[32*i +: 32] = res[i][31:0];
      end
    end
    osat_nxt = |clip;
  end

  always_ff @(posedge clk) begin
    if (en.s6) begin
      odata_r <= odata_nxt;
      osat_r  <= osat_nxt;
    end
  end

  assign out_tvalid   = vld_r[6];
  assign out_tdata    = odata_r;
  assign out_tuser[0] = osat_r;

endmodule
`default_nettype wire

// ===== rtl/qvr_checker.sv =====
// Port-level checks on the quaternion vector rotator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qvr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [95:0] out_tdata,
  input wire [0:0]  out_tuser,
  input wire        cfg_psel,
  input wire        cfg_penable,
  input wire        cfg_pready
);

  // No result may be offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // A held result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // When the output drains, every stage can move, so the input is open.
  a_drain_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked while output drains");

  // A saturated result has at least one component at a bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[31:0]  == 32'h7FFFFFFF || out_tdata[31:0]  == 32'h80000000 ||
      out_tdata[63:32] == 32'h7FFFFFFF || out_tdata[63:32] == 32'h80000000 ||
      out_tdata[95:64] == 32'h7FFFFFFF || out_tdata[95:64] == 32'h80000000)
    else $error("saturated flag without a clipped component");

  // The configuration port never inserts wait states.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable |-> cfg_pready)
    else $error("configuration access stalled");

endmodule

bind quaternion_vector_rotator qvr_checker u_qvr_checker (.*);
`default_nettype wire
